/* hdl/gsv_pkg.sv */
// Shared constants, codes and types of the signature check block.
`default_nettype none
package gsv_pkg;

	localparam int P_BITS    = 32;
	localparam int Q_BITS    = 16;
	localparam int HASH_BITS = 32;

	// datapath width of the serial modular unit
	localparam int UW = (P_BITS > HASH_BITS) ? P_BITS : HASH_BITS;
	localparam int CW = $clog2(UW);
	localparam int EW = $clog2(Q_BITS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = P_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIME_P      = 3'd0,
		REG_PRIME_Q      = 3'd1,
		REG_GENERATOR_A  = 3'd2,
		REG_PUBLIC_KEY_Y = 3'd3,
		REG_COMMIT_R     = 3'd4
	} cfg_reg_t;

	localparam logic [P_BITS-1:0] RST_PRIME_P      = P_BITS'(3);
	localparam logic [Q_BITS-1:0] RST_PRIME_Q      = Q_BITS'(2);
	localparam logic [P_BITS-1:0] RST_GENERATOR_A  = P_BITS'(1);
	localparam logic [P_BITS-1:0] RST_PUBLIC_KEY_Y = P_BITS'(1);
	localparam logic [Q_BITS-1:0] RST_COMMIT_R     = Q_BITS'(1);

	typedef enum logic {
		OP_REDUCE,
		OP_MULMOD
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HRED,
		ST_EDIV,
		ST_EMUL,
		ST_U1,
		ST_U2,
		ST_ARED,
		ST_APSQ,
		ST_APML,
		ST_YRED,
		ST_YPSQ,
		ST_YPML,
		ST_FMUL,
		ST_VRED,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* hdl/gsv_in_if.sv */
// Input channel: one hash element with its signature element.
`default_nettype none
interface gsv_in_if import gsv_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [HASH_BITS-1:0] hash_part;
	logic [Q_BITS-1:0]    sig_part;
	logic                 last_pair;

	modport source(output valid, hash_part, sig_part, last_pair, input ready);
	modport sink(input valid, hash_part, sig_part, last_pair, output ready);
endinterface
`default_nettype wire

/* hdl/gsv_out_if.sv */
// Output channel: per-element verdict flags.
`default_nettype none
interface gsv_out_if import gsv_pkg::*;;
	logic valid;
	logic ready;
	logic element_ok;
	logic all_ok;
	logic not_invertible;
	logic end_of_message;

	modport source(output valid, element_ok, all_ok, not_invertible, end_of_message,
		input ready);
	modport sink(input valid, element_ok, all_ok, not_invertible, end_of_message,
		output ready);
endinterface
`default_nettype wire

/* hdl/gost_signature_verify_core.sv */
// Top level: sequencer that verifies hash/signature element pairs.
`default_nettype none
// One pair is taken at a time. Each pair runs on a single bit-serial modular
// unit: a reduction runs one step per dividend bit, a modular multiply a
// doubling and an add step per multiplier bit, between issue and done. A pair
// takes the hash reduction, an extended Euclid inverse mod q (one divide and
// one multiply per quotient step, at most 23 steps), two multiplies for u1 and
// u2, two base reductions, two exponentiations mod p of 16 squarings and up to
// 16 multiplies each (a zero exponent bit skips its multiply), one final
// multiply and one reduction, plus the idle and output states; run time is set
// by the exponent bit patterns and the Euclid step count. A hash element with
// no inverse finishes after the hash reduction or the Euclid loop. The user must
// write configuration through cfg_we/cfg_index/cfg_data while idle; the block itself does not enforce it.
module gost_signature_verify_core import gsv_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	gsv_in_if.sink                     hash_ch,
	gsv_out_if.source                  res_ch
);

	logic [P_BITS-1:0] p_q, a_q, yk_q;
	logic [Q_BITS-1:0] q_q, r_q;

	state_t state_q, state_d;
	logic   issued_q;

	logic [HASH_BITS-1:0] h_q;
	logic [Q_BITS-1:0]    s_q;
	logic                 last_q;
	logic [Q_BITS-1:0]    r0_q, r1_q, t0_q, t1_q, quo_q, rem_q;
	logic [Q_BITS-1:0]    u1_q, u2_q;
	logic [P_BITS-1:0]    base_q, acc_q, pa_q;
	logic [EW-1:0]        ebit_q;
	logic                 notinv_q, match_q, run_q;

	logic outv_q, out_ok_q, out_all_q, out_ni_q, out_eom_q;

	unit_req_t         ureq;
	unit_rsp_t         ursp;
	logic [UW-1:0]     ux, uy, um, ures, uquo;

	logic              unit_state;
	logic              pml_bit;
	logic              skip;
	logic              adv;
	logic              out_load;
	logic [Q_BITS-1:0] eu_prod;
	logic [Q_BITS:0]   tsum;
	logic              all_now;

	gsv_modser u_modser (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.x      (ux),
		.y      (uy),
		.m      (um),
		.rsp    (ursp),
		.res    (ures),
		.quo    (uquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= RST_PRIME_P;
			q_q  <= RST_PRIME_Q;
			a_q  <= RST_GENERATOR_A;
			yk_q <= RST_PUBLIC_KEY_Y;
			r_q  <= RST_COMMIT_R;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRIME_P:      p_q  <= cfg_data[P_BITS-1:0];
				REG_PRIME_Q:      q_q  <= cfg_data[Q_BITS-1:0];
				REG_GENERATOR_A:  a_q  <= cfg_data[P_BITS-1:0];
				REG_PUBLIC_KEY_Y: yk_q <= cfg_data[P_BITS-1:0];
				REG_COMMIT_R:     r_q  <= cfg_data[Q_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pml_bit  = (state_q == ST_APML) ? u1_q[ebit_q] : u2_q[ebit_q];
		skip     = ((state_q == ST_APML) || (state_q == ST_YPML)) && !pml_bit;
		adv      = skip || ursp.done;
		out_load = (state_q == ST_DONE) && (!outv_q || res_ch.ready);
		eu_prod  = ures[Q_BITS-1:0];
		if (t0_q >= eu_prod) begin
			tsum = {1'b0, t0_q} - {1'b0, eu_prod};
		end else begin
			tsum = {1'b0, t0_q} + {1'b0, q_q} - {1'b0, eu_prod};
		end
		all_now  = run_q && match_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (hash_ch.valid) state_d = ST_HRED;
			ST_HRED: if (ursp.done) begin
				state_d = ((q_q < Q_BITS'(2)) || (ures == '0)) ? ST_DONE : ST_EDIV;
			end
			ST_EDIV: if (ursp.done) state_d = ST_EMUL;
			ST_EMUL: if (ursp.done) begin
				if (rem_q != '0) begin
					state_d = ST_EDIV;
				end else begin
					state_d = (r1_q == Q_BITS'(1)) ? ST_U1 : ST_DONE;
				end
			end
			ST_U1:   if (ursp.done) state_d = ST_U2;
			ST_U2:   if (ursp.done) state_d = ST_ARED;
			ST_ARED: if (ursp.done) state_d = ST_APSQ;
			ST_APSQ: if (ursp.done) state_d = ST_APML;
			ST_APML: if (adv) state_d = (ebit_q == '0) ? ST_YRED : ST_APSQ;
			ST_YRED: if (ursp.done) state_d = ST_YPSQ;
			ST_YPSQ: if (ursp.done) state_d = ST_YPML;
			ST_YPML: if (adv) state_d = (ebit_q == '0) ? ST_FMUL : ST_YPSQ;
			ST_FMUL: if (ursp.done) state_d = ST_VRED;
			ST_VRED: if (ursp.done) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit operands and handshake outputs
	always_comb begin
		ureq.op    = OP_REDUCE;
		ux         = '0;
		uy         = '0;
		um         = UW'(p_q);
		unit_state = 1'b1;
		unique case (state_q)
			ST_HRED: begin uy = UW'(h_q);  um = UW'(q_q); end
			ST_EDIV: begin uy = UW'(r0_q); um = UW'(r1_q); end
			ST_EMUL: begin
				ureq.op = OP_MULMOD; ux = UW'(t1_q); uy = UW'(quo_q); um = UW'(q_q);
			end
			ST_U1: begin
				ureq.op = OP_MULMOD; ux = UW'(t0_q); uy = UW'(s_q); um = UW'(q_q);
			end
			ST_U2: begin
				ureq.op = OP_MULMOD; ux = UW'(t0_q); uy = UW'(r_q); um = UW'(q_q);
			end
			ST_ARED: uy = UW'(a_q);
			ST_YRED: uy = UW'(yk_q);
			ST_APSQ, ST_YPSQ: begin
				ureq.op = OP_MULMOD; ux = UW'(acc_q); uy = UW'(acc_q);
			end
			ST_APML, ST_YPML: begin
				ureq.op = OP_MULMOD; ux = UW'(base_q); uy = UW'(acc_q);
			end
			ST_FMUL: begin
				ureq.op = OP_MULMOD; ux = UW'(pa_q); uy = UW'(acc_q);
			end
			ST_VRED: begin uy = UW'(acc_q); um = UW'(q_q); end
			ST_IDLE, ST_DONE: unit_state = 1'b0;
			default: unit_state = 1'b0;
		endcase
		ureq.start    = unit_state && !issued_q && !skip;
		hash_ch.ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			run_q    <= 1'b1;
			outv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ursp.done) begin
				issued_q <= 1'b0;
			end else if (ureq.start) begin
				issued_q <= 1'b1;
			end
			if (out_load) begin
				outv_q <= 1'b1;
				run_q  <= last_q ? 1'b1 : all_now;
			end else if (res_ch.ready) begin
				outv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q  <= match_q;
			out_all_q <= all_now;
			out_ni_q  <= notinv_q;
			out_eom_q <= last_q;
		end
		unique case (state_q)
			ST_IDLE: if (hash_ch.valid) begin
				h_q      <= hash_ch.hash_part;
				s_q      <= hash_ch.sig_part;
				last_q   <= hash_ch.last_pair;
				notinv_q <= 1'b0;
				match_q  <= 1'b0;
			end
			ST_HRED: if (ursp.done) begin
				notinv_q <= (q_q < Q_BITS'(2)) || (ures == '0);
				r0_q     <= q_q;
				r1_q     <= ures[Q_BITS-1:0];
				t0_q     <= '0;
				t1_q     <= Q_BITS'(1);
			end
			ST_EDIV: if (ursp.done) begin
				rem_q <= ures[Q_BITS-1:0];
				quo_q <= uquo[Q_BITS-1:0];
			end
			ST_EMUL: if (ursp.done) begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= tsum[Q_BITS-1:0];
				// gcd other than one: no inverse
				if (rem_q == '0 && r1_q != Q_BITS'(1)) begin
					notinv_q <= 1'b1;
				end
			end
			ST_U1: if (ursp.done) u1_q <= ures[Q_BITS-1:0];
			ST_U2: if (ursp.done) begin
				u2_q <= (ures == '0) ? '0 : (q_q - ures[Q_BITS-1:0]);
			end
			ST_ARED, ST_YRED: if (ursp.done) begin
				base_q <= ures[P_BITS-1:0];
				acc_q  <= (p_q < P_BITS'(2)) ? '0 : P_BITS'(1);
				ebit_q <= EW'(Q_BITS-1);
			end
			ST_APSQ, ST_YPSQ, ST_FMUL: if (ursp.done) acc_q <= ures[P_BITS-1:0];
			ST_APML, ST_YPML: if (adv) begin
				if (!skip) begin
					acc_q <= ures[P_BITS-1:0];
				end
				if (ebit_q != '0) begin
					ebit_q <= ebit_q - EW'(1);
				end else if (state_q == ST_APML) begin
					pa_q <= skip ? acc_q : ures[P_BITS-1:0];
				end
			end
			ST_VRED: if (ursp.done) match_q <= (ures == UW'(r_q));
			ST_DONE: ;
			default: ;
		endcase
	end

	assign res_ch.valid          = outv_q;
	assign res_ch.element_ok     = out_ok_q;
	assign res_ch.all_ok         = out_all_q;
	assign res_ch.not_invertible = out_ni_q;
	assign res_ch.end_of_message = out_eom_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ureq.start |-> !ursp.busy)
		else $error("unit started while busy");
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(hash_ch.valid && hash_ch.ready) |=> (state_q == ST_HRED))
		else $error("transfer did not start the sequence");
	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		ursp.done |-> (issued_q && state_q != ST_IDLE && state_q != ST_DONE))
		else $error("unit finished without a pending operation");
	a_ni_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> !(res_ch.not_invertible && res_ch.element_ok))
		else $error("non-invertible element reported as match");
`endif

endmodule
`default_nettype wire

/* hdl/gsv_modser.sv */
// Bit-serial modular unit: remainder/quotient and modular multiply, MSB first.
`default_nettype none
module gsv_modser import gsv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire unit_req_t     req,
	input  wire logic [UW-1:0] x,
	input  wire logic [UW-1:0] y,
	input  wire logic [UW-1:0] m,
	output unit_rsp_t          rsp,
	output logic [UW-1:0]      res,
	output logic [UW-1:0]      quo
);

	logic          busy_q;
	logic          done_q;
	op_t           op_q;
	logic          ph_q;
	logic [CW-1:0] cnt_q;
	logic [UW-1:0] x_q;
	logic [UW-1:0] y_q;
	logic [UW-1:0] m_q;
	logic [UW-1:0] acc_q;
	logic [UW-1:0] quo_q;

	logic          ybit;
	logic          dbl;
	logic          ge;
	logic          last_step;
	logic [UW:0]   t;
	logic [UW:0]   t_red;

	always_comb begin
		ybit = y_q[UW-1];
		// doubling step: reduce shifts in the dividend bit, multiply shifts in zero
		dbl  = (op_q == OP_REDUCE) || !ph_q;
		if (dbl) begin
			t = {acc_q, (op_q == OP_REDUCE) ? ybit : 1'b0};
		end else begin
			t = {1'b0, acc_q} + (ybit ? {1'b0, x_q} : {(UW+1){1'b0}});
		end
		ge        = (t >= {1'b0, m_q});
		t_red     = ge ? (t - {1'b0, m_q}) : t;
		last_step = (cnt_q == CW'(UW-1)) && ((op_q == OP_REDUCE) || ph_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (op_q == OP_REDUCE || ph_q) begin
					cnt_q <= cnt_q + CW'(1);
				end
				ph_q <= (op_q == OP_MULMOD) && !ph_q;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
			acc_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			acc_q <= t_red[UW-1:0];
			if (op_q == OP_REDUCE) begin
				quo_q <= {quo_q[UW-2:0], ge};
			end
			if (op_q == OP_REDUCE || ph_q) begin
				y_q <= {y_q[UW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	// a zero modulus reduces everything to zero
	assign res      = (m_q == '0) ? '0 : acc_q;
	assign quo      = quo_q;

endmodule
`default_nettype wire

/* verif/tb_gost_signature_verify_core.sv */
// Testbench for the GOST style signature check core: scoreboard, stimulus and checks.
`timescale 1ns / 1ps
`default_nettype none

class verdict_scoreboard;
	logic [gsv_pkg::P_BITS-1:0] mod_p;
	logic [gsv_pkg::Q_BITS-1:0] mod_q;
	logic [gsv_pkg::P_BITS-1:0] base_a;
	logic [gsv_pkg::P_BITS-1:0] key_y;
	logic [gsv_pkg::Q_BITS-1:0] sig_r;
	bit running;
	logic [3:0] verdicts[$];
	int mismatches;

	function new();
		mod_p = gsv_pkg::RST_PRIME_P;
		mod_q = gsv_pkg::RST_PRIME_Q;
		base_a = gsv_pkg::RST_GENERATOR_A;
		key_y = gsv_pkg::RST_PUBLIC_KEY_Y;
		sig_r = gsv_pkg::RST_COMMIT_R;
		running = 1'b1;
		mismatches = 0;
	endfunction

	function void write_reg(gsv_pkg::cfg_reg_t idx, logic [31:0] val);
		case (idx)
			gsv_pkg::REG_PRIME_P: mod_p = val;
			gsv_pkg::REG_PRIME_Q: mod_q = val[15:0];
			gsv_pkg::REG_GENERATOR_A: base_a = val;
			gsv_pkg::REG_PUBLIC_KEY_Y: key_y = val;
			gsv_pkg::REG_COMMIT_R: sig_r = val[15:0];
			default: ;
		endcase
	endfunction

	function longint unsigned mulm(longint unsigned x, longint unsigned y,
			longint unsigned m);
		if (m == 0) return 0;
		return (x % m) * (y % m) % m;
	endfunction

	function longint unsigned powm(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		if (m == 0) return 0;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = mulm(acc, b, m);
			b = mulm(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// extended Euclid; returns 0 when no inverse exists
	function bit invert(longint unsigned h, longint unsigned q, output longint unsigned inv);
		longint r0, r1, t0, t1, quo, tmp;
		inv = 0;
		if (q < 2) return 0;
		h = h % q;
		if (h == 0) return 0;
		r0 = q; r1 = h; t0 = 0; t1 = 1;
		while (r1 != 0) begin
			quo = r0 / r1;
			tmp = r0 - quo * r1; r0 = r1; r1 = tmp;
			tmp = t0 - quo * t1; t0 = t1; t1 = tmp;
		end
		if (r0 != 1) return 0;
		if (t0 < 0) t0 += q;
		inv = t0;
		return 1;
	endfunction

	function void note_pair(logic [31:0] h, logic [15:0] s, logic last);
		longint unsigned hinv, u1, t, u2, prod;
		bit ok, match, all;
		match = 0;
		ok = invert(h, mod_q, hinv);
		if (ok) begin
			u1 = mulm(s, hinv, mod_q);
			t = mulm(sig_r, hinv, mod_q);
			u2 = (t == 0) ? 0 : mod_q - t;
			prod = mulm(powm(base_a, u1, mod_p), powm(key_y, u2, mod_p), mod_p);
			match = ((mod_q == 0 ? 0 : prod % mod_q) == sig_r);
		end
		all = running && match;
		running = last ? 1'b1 : all;
		verdicts.insert(verdicts.size(), {match, all, !ok, last});
	endfunction

	function void check_verdict(logic [3:0] got);
		logic [3:0] exp;
		if (verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %b", got);
			return;
		end
		exp = verdicts.pop_front();
		if (got !== exp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp ok/all/noinv/eom=%b got=%b", exp, got);
		end
	endfunction
endclass

module tb_gost_signature_verify_core;
	import gsv_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gsv_in_if hash_ch();
	gsv_out_if res_ch();

	gost_signature_verify_core u_dut(
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .hash_ch(hash_ch.sink), .res_ch(res_ch.source)
	);

	verdict_scoreboard board = new();
	bit quiet_phase = 0;
	bit long_hold = 0;
	int idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		hash_ch.valid = 1'b0;
		hash_ch.hash_part = '0;
		hash_ch.sig_part = '0;
		hash_ch.last_pair = 1'b0;
		res_ch.ready = 1'b0;
	end

	// receiver with random stall bursts; a long hold-off when asked
	initial begin : sink_proc
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				res_ch.ready <= 1'b0;
				for (n = 0; n < 15000; n++) @(negedge clk);
				long_hold = 0;
				res_ch.ready <= 1'b1;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			board.check_verdict({res_ch.element_ok, res_ch.all_ok,
				res_ch.not_invertible, res_ch.end_of_message});
		if ((hash_ch.valid && hash_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("gost_signature_verify_core regression: fail");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		board.write_reg(idx, val);
	endtask

	// valid stays up after the transfer until the next pair or a drain
	task automatic send_pair(logic [31:0] h, logic [15:0] s, logic last);
		if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			hash_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		hash_ch.valid <= 1'b1;
		hash_ch.hash_part <= h;
		hash_ch.sig_part <= s;
		hash_ch.last_pair <= last;
		do @(posedge clk); while (!hash_ch.ready);
		board.note_pair(h, s, last);
		@(negedge clk);
	endtask

	task automatic drain();
		hash_ch.valid <= 1'b0;
		while (board.verdicts.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// parameter sets: small groups, then one with wide values
	task automatic load_group(int sel);
		logic [31:0] p, a, x;
		logic [15:0] q;
		case (sel)
			0: begin p = 32'd23; q = 16'd11; a = 32'd4; end
			1: begin p = 32'd107; q = 16'd53; a = 32'd4; end
			2: begin p = 32'd2267; q = 16'd103; a = 32'(2 ** 22 % 2267); end
			default: begin p = 32'hFFFFFFFB; q = 16'hFFF1; a = 32'hFFFFFFFF; end
		endcase
		x = $urandom_range(1, q - 1);
		write_reg(REG_PRIME_P, p);
		write_reg(REG_PRIME_Q, 32'(q));
		write_reg(REG_GENERATOR_A, a);
		write_reg(REG_PUBLIC_KEY_Y, 32'(board.powm(a, x, p)));
		write_reg(REG_COMMIT_R, $urandom_range(0, q - 1));
	endtask

	// random pair; now and then a hash that is a multiple of q
	task automatic send_random(logic last);
		logic [31:0] h;
		logic [15:0] s;
		h = $urandom();
		if ($urandom_range(0, 9) == 0) h = board.mod_q * $urandom_range(0, 3);
		s = 16'($urandom());
		send_pair(h, s, last);
	endtask

	initial begin : main
		int i, ph;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset values, field extremes
		send_pair(32'h0, 16'h0, 1'b0);
		send_pair(32'hFFFFFFFF, 16'hFFFF, 1'b1);
		send_pair(32'h1, 16'h1, 1'b1);
		drain();
		write_reg(REG_PRIME_Q, 32'd0);
		send_pair(32'd5, 16'd3, 1'b1);
		drain();
		write_reg(REG_PRIME_Q, 32'd1);
		write_reg(REG_PRIME_P, 32'd0);
		send_pair(32'd5, 16'd3, 1'b1);
		drain();
		// composite q: gcd not one; p of one
		write_reg(REG_PRIME_Q, 32'd12);
		write_reg(REG_PRIME_P, 32'd1);
		write_reg(REG_COMMIT_R, 32'd0);
		send_pair(32'd6, 16'd5, 1'b0);
		send_pair(32'd5, 16'd5, 1'b1);
		drain();
		// r at or above q never matches; s above q
		load_group(0);
		write_reg(REG_COMMIT_R, 32'h0000FFFF);
		send_pair(32'd3, 16'hFFFF, 1'b1);
		drain();
		load_group(3);
		send_pair(32'hFFFFFFFF, 16'hFFFF, 1'b0);
		send_pair(32'h0000FFF1, 16'h0, 1'b0);
		send_pair(32'h12345678, 16'h8000, 1'b1);
		drain();

		// genuine signatures on a small group, running flag over messages
		load_group(1);
		begin
			longint unsigned k, xk, r, hh, ss;
			xk = $urandom_range(1, 52);
			write_reg(REG_PUBLIC_KEY_Y, 32'(board.powm(4, xk, 107)));
			k = $urandom_range(1, 52);
			r = board.powm(4, k, 107) % 53;
			write_reg(REG_COMMIT_R, 32'(r));
			for (i = 0; i < 6; i++) begin
				hh = $urandom_range(1, 52);
				ss = (xk * r + k * hh) % 53;
				if (i == 2) ss = (ss + 1) % 53;
				send_pair(32'(hh), 16'(ss), i == 3 || i == 5);
			end
		end
		drain();

		// pressure: receiver holds off while the sender keeps going
		long_hold = 1;
		for (i = 0; i < 6; i++) send_random(1'($urandom_range(0, 1)));
		drain();

		for (ph = 0; ph < 8; ph++) begin
			load_group(ph % 4);
			if (ph == 7) quiet_phase = 1;
			for (i = 0; i < 33; i++) send_random($urandom_range(0, 3) == 0);
			drain();
		end

		if (board.mismatches == 0 && board.verdicts.size() == 0)
			$display("gost_signature_verify_core regression: pass");
		else
			$display("gost_signature_verify_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
